// File: hdl/bpfr_pkg.sv
// Shared types and constants for the byte pattern find and replace block.
`default_nettype none

package bpfr_pkg;

    localparam int PATTERN_MAX = 64;
    localparam int REPLACE_MAX = 128;
    localparam int PAT_IDX_W   = $clog2(PATTERN_MAX);
    localparam int REP_IDX_W   = $clog2(REPLACE_MAX);
    localparam int FILL_W      = PAT_IDX_W + 1;
    localparam int PLEN_W      = 7;
    localparam int RLEN_W      = 8;
    localparam int CFG_DATA_W  = 8;
    localparam int COUNT_W     = 16;
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = QUEUE_PTR_W + 1;

    localparam logic [1:0] REQ_DATA = 2'd0;
    localparam logic [1:0] REQ_PAT  = 2'd1;
    localparam logic [1:0] REQ_REPL = 2'd2;

    localparam logic CFG_PATTERN_LENGTH = 1'b0;
    localparam logic CFG_REPLACE_LENGTH = 1'b1;

    typedef enum logic [1:0] {
        OP_DATA,
        OP_PAT,
        OP_REPL
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [6:0] idx;
        logic [7:0] data;
        logic       eos;
    } t_item;

endpackage

`default_nettype wire

// File: hdl/bpfr_front.sv
// Input stage: accept request beats, decode and drop unused ones.
`default_nettype none

module bpfr_front (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output logic                o_in_ready,
    input  wire logic [1:0]     i_req_type,
    input  wire logic [6:0]     i_table_index,
    input  wire logic [7:0]     i_byte_value,
    input  wire logic           i_end_of_stream,
    output logic                o_valid,
    output bpfr_pkg::t_item     o_item,
    input  wire logic           i_ready
);

    logic            r_valid;
    bpfr_pkg::t_item r_item;
    bpfr_pkg::t_item n_item;
    logic            keep;

    always_comb begin
        n_item      = '0;
        n_item.idx  = i_table_index;
        n_item.data = i_byte_value;
        keep        = 1'b0;
        case (i_req_type)
            bpfr_pkg::REQ_DATA: begin
                n_item.op  = bpfr_pkg::OP_DATA;
                n_item.eos = i_end_of_stream;
                keep       = 1'b1;
            end
            bpfr_pkg::REQ_PAT: begin
                n_item.op = bpfr_pkg::OP_PAT;
                keep      = (i_table_index < 7'(bpfr_pkg::PATTERN_MAX));
            end
            bpfr_pkg::REQ_REPL: begin
                n_item.op = bpfr_pkg::OP_REPL;
                keep      = ({1'b0, i_table_index} < 8'(bpfr_pkg::REPLACE_MAX));
            end
            default: begin
                n_item.op = bpfr_pkg::OP_DATA;
                keep      = 1'b0;
            end
        endcase
    end

    assign o_in_ready = !r_valid || i_ready;
    assign o_valid    = r_valid;
    assign o_item     = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_in_valid && o_in_ready) begin
            r_valid <= keep;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_item <= n_item;
        end
    end

endmodule

`default_nettype wire

// File: hdl/bpfr_queue.sv
// Short queue of decoded requests between the front and back stages.
`default_nettype none

module bpfr_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    input  wire bpfr_pkg::t_item i_item,
    output logic                o_ready,
    output logic                o_valid,
    output bpfr_pkg::t_item     o_item,
    input  wire logic           i_pop
);

    bpfr_pkg::t_item                     r_mem [bpfr_pkg::QUEUE_DEPTH];
    logic [bpfr_pkg::QUEUE_PTR_W-1:0]    r_wr;
    logic [bpfr_pkg::QUEUE_PTR_W-1:0]    r_rd;
    logic [bpfr_pkg::QUEUE_CNT_W-1:0]    r_cnt;
    logic                                push;
    logic                                pop;

    assign o_ready = (r_cnt != bpfr_pkg::QUEUE_CNT_W'(bpfr_pkg::QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_item  = r_mem[r_rd];
    assign push    = i_valid && o_ready;
    assign pop     = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (pop) begin
                r_rd <= r_rd + 1'b1;
            end
            case ({push, pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= i_item;
        end
    end

endmodule

`default_nettype wire

// File: hdl/bpfr_back.sv
// Window engine: append bytes, compare with the pattern, replace, emit and flush.
`default_nettype none

module bpfr_back (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_we,
    input  wire logic                        i_cfg_index,
    input  wire logic [bpfr_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                        i_q_valid,
    input  wire bpfr_pkg::t_item             i_q_item,
    output logic                             o_q_pop,
    output logic                             o_out_valid,
    input  wire logic                        i_out_ready,
    output logic [7:0]                       o_out_byte,
    output logic                             o_match_here,
    output logic [bpfr_pkg::COUNT_W-1:0]     o_match_count,
    output logic                             o_out_last
);

    localparam int PM  = bpfr_pkg::PATTERN_MAX;
    localparam int FW  = bpfr_pkg::FILL_W;
    localparam int RIW = bpfr_pkg::REP_IDX_W;
    localparam int PIW = bpfr_pkg::PAT_IDX_W;
    localparam int RLW = bpfr_pkg::RLEN_W;
    localparam int CW  = bpfr_pkg::COUNT_W;

    logic [bpfr_pkg::PLEN_W-1:0] r_plen;
    logic [RLW-1:0]              r_rlen;

    logic [7:0]     r_win     [PM];
    logic [7:0]     r_pat     [PM];
    logic [7:0]     r_rep_lo  [PM];
    logic [7:0]     r_rep_mem [bpfr_pkg::REPLACE_MAX];
    logic [7:0]     r_rd_cur;
    logic [7:0]     r_rd_fill;

    logic [FW-1:0]  r_fill;
    logic           r_run;
    logic           r_flush;
    logic [RIW-1:0] r_cur;
    logic           r_act;
    logic [CW-1:0]  r_matches;

    logic           r_out_valid;
    logic [7:0]     r_out_byte;
    logic           r_out_hit;
    logic [CW-1:0]  r_out_count;
    logic           r_out_last;

    logic [7:0]     n_win [PM];
    logic [FW-1:0]  n_fill;
    logic           n_run;
    logic           n_flush;
    logic [RIW-1:0] n_cur;
    logic           n_act;
    logic [CW-1:0]  n_matches;

    logic [FW-1:0]  plen;
    logic [RLW-1:0] rlen;
    logic [PM-1:0]  lane_ok;
    logic           hit;
    logic           emit;
    logic           emit_fire;
    logic           iter_hit;
    logic           stream_end;
    logic [7:0]     w_ov [PM];
    logic [CW-1:0]  cnt_emit;
    logic [FW-1:0]  fill1;
    logic           run1;
    logic           flush1;
    logic [RIW-1:0] cur1;
    logic           act1;
    logic           from_hit;
    logic [RLW-1:0] cur_ext;
    logic [RLW-1:0] cur_inc;
    logic [7:0]     rep_byte;
    logic [7:0]     app_byte;
    logic           pop;
    logic           is_data;
    logic           rep_we;
    logic [RIW-1:0] rep_waddr;

    always_comb begin
        if (r_plen == '0) begin
            plen = FW'(1);
        end else if (r_plen > bpfr_pkg::PLEN_W'(PM)) begin
            plen = FW'(PM);
        end else begin
            plen = FW'(r_plen);
        end
        if (r_rlen > RLW'(bpfr_pkg::REPLACE_MAX)) begin
            rlen = RLW'(bpfr_pkg::REPLACE_MAX);
        end else begin
            rlen = r_rlen;
        end
    end

    always_comb begin
        for (int j = 0; j < PM; j++) begin
            lane_ok[j] = (FW'(j) >= plen) || (r_win[j] == r_pat[j]);
        end
        hit = &lane_ok;
    end

    always_comb begin
        emit       = r_run || r_flush;
        emit_fire  = emit && (!r_out_valid || i_out_ready);
        iter_hit   = emit_fire && r_run && hit;
        stream_end = emit_fire && r_flush && (r_fill == FW'(1));

        for (int j = 0; j < PM; j++) begin
            w_ov[j] = (iter_hit && (RLW'(j) < rlen)) ? r_rep_lo[j] : r_win[j];
        end

        if (iter_hit && (r_matches != {CW{1'b1}})) begin
            cnt_emit = r_matches + 1'b1;
        end else begin
            cnt_emit = r_matches;
        end

        fill1  = emit_fire ? (r_fill - 1'b1) : r_fill;
        run1   = emit_fire ? (fill1 >= plen) : r_run;
        flush1 = emit_fire ? (r_flush && (fill1 != '0)) : r_flush;

        from_hit = 1'b0;
        if (stream_end) begin
            cur1 = '0;
            act1 = 1'b0;
        end else if (iter_hit) begin
            from_hit = 1'b1;
            if (rlen > RLW'(r_fill)) begin
                cur1 = RIW'(r_fill);
                act1 = 1'b1;
            end else begin
                cur1 = '0;
                act1 = 1'b0;
            end
        end else begin
            cur1 = r_cur;
            act1 = r_act;
        end

        pop     = i_q_valid && !run1 && !flush1;
        is_data = pop && (i_q_item.op == bpfr_pkg::OP_DATA);

        cur_ext  = RLW'(cur1);
        cur_inc  = cur_ext + 1'b1;
        rep_byte = from_hit ? r_rd_fill : r_rd_cur;
        app_byte = i_q_item.data;
        n_cur    = cur1;
        n_act    = act1;
        if (is_data && act1) begin
            if (cur_ext < rlen) begin
                app_byte = rep_byte;
                if (cur_inc >= rlen) begin
                    n_cur = '0;
                    n_act = 1'b0;
                end else begin
                    n_cur = RIW'(cur_inc);
                end
            end else begin
                n_cur = '0;
                n_act = 1'b0;
            end
        end

        for (int j = 0; j < PM; j++) begin
            if (emit_fire) begin
                n_win[j] = (j < PM - 1) ? w_ov[(j + 1) % PM] : w_ov[j];
            end else begin
                n_win[j] = r_win[j];
            end
        end
        if (is_data) begin
            n_win[fill1[PIW-1:0]] = app_byte;
        end

        n_fill  = is_data ? (fill1 + 1'b1) : fill1;
        n_run   = is_data ? ((fill1 + 1'b1) >= plen) : run1;
        n_flush = is_data ? i_q_item.eos : flush1;

        if (stream_end) begin
            n_matches = '0;
        end else begin
            n_matches = cnt_emit;
        end

        rep_we    = pop && (i_q_item.op == bpfr_pkg::OP_REPL);
        rep_waddr = i_q_item.idx[RIW-1:0];
    end

    assign o_q_pop       = pop;
    assign o_out_valid   = r_out_valid;
    assign o_out_byte    = r_out_byte;
    assign o_match_here  = r_out_hit;
    assign o_match_count = r_out_count;
    assign o_out_last    = r_out_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_plen      <= bpfr_pkg::PLEN_W'(1);
            r_rlen      <= '0;
            r_fill      <= '0;
            r_run       <= 1'b0;
            r_flush     <= 1'b0;
            r_cur       <= '0;
            r_act       <= 1'b0;
            r_matches   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    bpfr_pkg::CFG_PATTERN_LENGTH: r_plen <= i_cfg_data[bpfr_pkg::PLEN_W-1:0];
                    bpfr_pkg::CFG_REPLACE_LENGTH: r_rlen <= i_cfg_data[RLW-1:0];
                    default:                      r_rlen <= r_rlen;
                endcase
            end
            r_fill    <= n_fill;
            r_run     <= n_run;
            r_flush   <= n_flush;
            r_cur     <= n_cur;
            r_act     <= n_act;
            r_matches <= n_matches;
            if (emit_fire) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int j = 0; j < PM; j++) begin
            r_win[j] <= n_win[j];
        end
        if (pop && (i_q_item.op == bpfr_pkg::OP_PAT)) begin
            r_pat[i_q_item.idx[PIW-1:0]] <= i_q_item.data;
        end
        if (rep_we && (rep_waddr < RIW'(PM))) begin
            r_rep_lo[rep_waddr[PIW-1:0]] <= i_q_item.data;
        end
        if (emit_fire) begin
            r_out_byte  <= w_ov[0];
            r_out_hit   <= iter_hit;
            r_out_count <= cnt_emit;
            r_out_last  <= r_flush && (r_fill == FW'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (rep_we) begin
            r_rep_mem[rep_waddr] <= i_q_item.data;
        end
        if (rep_we && (rep_waddr == n_cur)) begin
            r_rd_cur <= i_q_item.data;
        end else begin
            r_rd_cur <= r_rep_mem[n_cur];
        end
        if (rep_we && (rep_waddr == RIW'(n_fill))) begin
            r_rd_fill <= i_q_item.data;
        end else begin
            r_rd_fill <= r_rep_mem[RIW'(n_fill)];
        end
    end

endmodule

`default_nettype wire

// File: hdl/byte_pattern_find_replace.sv
// Top level of the streaming byte pattern find and replace block.
// Input channel (i_in_valid / o_in_ready) carries data bytes and table writes:
// req_type 0 is a data byte, 1 writes the pattern table, 2 the replacement table.
// Configuration writes (i_cfg_we, i_cfg_index, i_cfg_data) set pattern_length and
// replace_length; issue them only while the block is idle.
// Output channel (o_out_valid / i_out_ready) carries one beat per final byte with
// its match flag, running match count and last flag.
// Throughput: one beat in and one beat out per cycle in steady state while
// i_out_ready stays high. A byte leaves pattern_length - 1 bytes after it enters;
// the beat that completes its window passes the decode register, queue, append
// and compare before it reaches the output. After the end-of-stream byte the
// window is flushed. Table writes take one back-end slot each. A shrunk pattern
// length adds a compare and emit per surplus window byte on the next data byte.
// Compare, replace and emit run in the same cycle over the full 64-byte window.
// Reset clears the queue, window fill, pending replacement and match count, and
// sets pattern_length to 1 and replace_length to 0; table contents are undefined
// until written.
// When the receiver stalls the output register holds, the back end stops once its
// window is full, the queue fills and o_in_ready drops.
`default_nettype none

module byte_pattern_find_replace (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic                            i_cfg_index,
    input  wire logic [bpfr_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                            i_in_valid,
    output logic                                 o_in_ready,
    input  wire logic [1:0]                      i_req_type,
    input  wire logic [6:0]                      i_table_index,
    input  wire logic [7:0]                      i_byte_value,
    input  wire logic                            i_end_of_stream,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_ready,
    output logic [7:0]                           o_out_byte,
    output logic                                 o_match_here,
    output logic [bpfr_pkg::COUNT_W-1:0]         o_match_count,
    output logic                                 o_out_last
);

    logic            f_valid;
    bpfr_pkg::t_item f_item;
    logic            q_ready;
    logic            q_valid;
    bpfr_pkg::t_item q_item;
    logic            q_pop;

    bpfr_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_req_type      (i_req_type),
        .i_table_index   (i_table_index),
        .i_byte_value    (i_byte_value),
        .i_end_of_stream (i_end_of_stream),
        .o_valid         (f_valid),
        .o_item          (f_item),
        .i_ready         (q_ready)
    );

    bpfr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (f_valid),
        .i_item  (f_item),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .o_item  (q_item),
        .i_pop   (q_pop)
    );

    bpfr_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_q_valid     (q_valid),
        .i_q_item      (q_item),
        .o_q_pop       (q_pop),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_out_byte    (o_out_byte),
        .o_match_here  (o_match_here),
        .o_match_count (o_match_count),
        .o_out_last    (o_out_last)
    );

endmodule

`default_nettype wire
